### rtl/core/cqg_pkg.sv
// Shared types, codes and constants of the committed memory quota guard.
package cqg_pkg;

    // Field widths.
    localparam int ADDR_W   = 48;
    localparam int LEN_W    = 48;
    localparam int START_W  = 49;
    localparam int END_W    = 50;
    localparam int USED_W   = 50;
    localparam int RCAP_W   = 49;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int LIMIT_W  = 35;

    // Default number of region table slots.
    localparam int DEFAULT_REGION_SLOTS = 64;

    // Largest cap: 16 GiB.
    localparam logic [LIMIT_W-1:0] MAX_CAP = 35'h4_0000_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_CONFIGURED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_USED   = 2'd2;

    typedef enum logic [1:0] {
        OP_MAP      = 2'd0,
        OP_PROTECT  = 2'd1,
        OP_UNMAP    = 2'd2,
        OP_HEADROOM = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_REFUSED  = 2'd1,
        STAT_OS_FAIL  = 2'd2,
        STAT_HEADROOM = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_WALK_WR,
        ST_POST,
        ST_APPEND,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        WM_UNTRACK,
        WM_COMMIT_SUM,
        WM_APPLY_COMMIT,
        WM_DECOMMIT
    } walk_mode_t;

    // One region table entry.
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   size;
        logic [LEN_W-1:0]   charged;
    } region_entry_t;

    // Registered overlap evaluation of one entry against the request range.
    typedef struct packed {
        logic [START_W-1:0] is_lo;
        logic [START_W-1:0] ie_hi;
        logic [START_W-1:0] rs;
        logic [END_W-1:0]   re;
        logic [LEN_W-1:0]   size;
        logic [LEN_W-1:0]   charged;
    } region_eval_t;

endpackage

### rtl/core/committed_memory_quota_guard.sv
// Top level of the committed memory quota guard: sequencer and byte accounting.
//
// Usage: requests arrive on the s_ channel (valid/ready) and every request gives
// exactly one result beat on the m_ channel (status, returned cap, used bytes).
// The configuration port writes cap enable, cap limit or the used baseline; write
// it only while no request is in flight. A map without fixed placement goes from
// dispatch through the append step to the result, and arm headroom, a refused or
// failed map and a failed protect without access go from dispatch straight to the
// result. Every walk over the region table handles each recorded region in turn
// (memory read, overlap stage, write back): unmap and protect without access walk
// once, fixed map walks once and then appends, and protect with access walks
// twice unless it is refused or fails. The region count is at most REGION_SLOTS.
// One request is processed at a time; the next one is accepted as soon as the
// sequencer is back in idle, even while a result still waits.
// The result register holds its beat while m_ready is low and the sequencer
// stalls before writing a new result. Reset clears the counters, the cap, the
// cap enable and the region count; the table needs no clearing pass.
module committed_memory_quota_guard #(
    parameter int REGION_SLOTS = cqg_pkg::DEFAULT_REGION_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cqg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cqg_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [cqg_pkg::ADDR_W-1:0]     s_base_address,
    input  logic [cqg_pkg::LEN_W-1:0]      s_length,
    input  logic                           s_usable_access,
    input  logic                           s_fixed_placement,
    input  logic                           s_os_succeeded,
    input  logic [cqg_pkg::LEN_W-1:0]      s_headroom_bytes,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [cqg_pkg::RCAP_W-1:0]     m_returned_cap,
    output logic signed [cqg_pkg::USED_W-1:0] m_used_bytes
);
    import cqg_pkg::*;

    localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_W = $clog2(REGION_SLOTS + 1);
    localparam int ACC_W = LEN_W + CNT_W + 1;
    localparam int D_W   = ACC_W + 2;
    localparam int SUM_W = ACC_W + 3;
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(REGION_SLOTS);
    localparam logic signed [SUM_W-1:0] POS_MAX =
        $signed({{(SUM_W-49){1'b0}}, {49{1'b1}}});

    // Control and accounting state.
    state_t     state_reg, state_next;
    walk_mode_t mode_reg, mode_next;
    logic signed [USED_W-1:0] used_reg, used_next;
    logic signed [USED_W-1:0] cap_reg, cap_next;
    logic       cap_en_reg, cap_en_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [ACC_W-1:0] acc_a_reg, acc_a_next;
    logic [ACC_W-1:0] acc_b_reg, acc_b_next;
    status_t    status_reg, status_next;
    logic [RCAP_W-1:0] rcap_reg, rcap_next;
    logic       m_valid_reg, m_valid_next;
    status_t    m_status_reg, m_status_next;
    logic [RCAP_W-1:0] m_rcap_reg, m_rcap_next;
    logic signed [USED_W-1:0] m_used_reg, m_used_next;

    // Latched request.
    op_t               op_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [START_W-1:0] end_reg;
    logic              usable_reg;
    logic              fixed_reg;
    logic              os_ok_reg;
    logic [LEN_W-1:0]  hb_reg;

    // Memory and overlap stage.
    logic          mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    region_entry_t mem_wdata, mem_rdata;
    region_eval_t  ev;

    // Datapath intermediates.
    logic [LEN_W-1:0]  map_c;
    logic signed [SUM_W-1:0] used_ext, cap_ext, map_sum, charge_sum, hb_sum, nc;
    logic signed [D_W-1:0]   d_val;
    logic              d_pos, hb_bad;
    logic              ov, full, head;
    logic [LEN_W-1:0]  inter, rel;
    region_entry_t     upd;

    cqg_region_mem #(
        .DEPTH (REGION_SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    cqg_region_eval u_eval (
        .aclk       (aclk),
        .load       (state_reg == ST_WALK_EV),
        .entry      (mem_rdata),
        .range_base (base_reg),
        .range_end  (end_reg),
        .result     (ev)
    );

    // Request latch.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= op_t'(s_operation);
            base_reg   <= s_base_address;
            len_reg    <= s_length;
            end_reg    <= START_W'(s_base_address) + START_W'(s_length);
            usable_reg <= s_usable_access;
            fixed_reg  <= s_fixed_placement;
            os_ok_reg  <= s_os_succeeded;
            hb_reg     <= s_headroom_bytes;
        end
    end

    // Control and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= WM_UNTRACK;
            used_reg     <= '0;
            cap_reg      <= '0;
            cap_en_reg   <= 1'b0;
            count_reg    <= '0;
            idx_reg      <= '0;
            wr_reg       <= '0;
            acc_a_reg    <= '0;
            acc_b_reg    <= '0;
            status_reg   <= STAT_OK;
            rcap_reg     <= '0;
            m_valid_reg  <= 1'b0;
            m_status_reg <= STAT_OK;
            m_rcap_reg   <= '0;
            m_used_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            used_reg     <= used_next;
            cap_reg      <= cap_next;
            cap_en_reg   <= cap_en_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            wr_reg       <= wr_next;
            acc_a_reg    <= acc_a_next;
            acc_b_reg    <= acc_b_next;
            status_reg   <= status_next;
            rcap_reg     <= rcap_next;
            m_valid_reg  <= m_valid_next;
            m_status_reg <= m_status_next;
            m_rcap_reg   <= m_rcap_next;
            m_used_reg   <= m_used_next;
        end
    end

    // Charge sums and headroom arithmetic.
    always_comb begin
        map_c      = usable_reg ? len_reg : '0;
        used_ext   = SUM_W'(used_reg);
        cap_ext    = SUM_W'(cap_reg);
        map_sum    = used_ext + $signed(SUM_W'(map_c));
        d_val      = $signed(D_W'(len_reg)) + $signed(D_W'(acc_a_reg))
                     - $signed(D_W'(acc_b_reg));
        d_pos      = (d_val > $signed(D_W'(0)));
        charge_sum = used_ext + SUM_W'(d_val);
        hb_bad     = (hb_reg == '0) || (hb_reg > LEN_W'(MAX_CAP));
        hb_sum     = used_ext + $signed(SUM_W'(hb_reg));
        nc         = (hb_sum > POS_MAX) ? $signed(SUM_W'(MAX_CAP)) : hb_sum;
        if (cap_en_reg && (nc > cap_ext)) begin
            nc = cap_ext;
        end
    end

    // Per-entry clipping of the evaluated region.
    always_comb begin
        ov    = (ev.is_lo < ev.ie_hi);
        inter = LEN_W'(ev.ie_hi - ev.is_lo);
        rel   = (ev.charged < inter) ? ev.charged : inter;
        head  = (ev.is_lo <= ev.rs);
        full  = head && (END_W'(ev.ie_hi) >= ev.re);
        upd.start   = ev.rs;
        upd.size    = ev.size;
        upd.charged = ev.charged;
        if (ov) begin
            upd.charged = ev.charged - rel;
            if (head) begin
                upd.start = ev.ie_hi;
                upd.size  = LEN_W'(ev.re - END_W'(ev.ie_hi));
            end else begin
                upd.size  = LEN_W'(ev.is_lo - ev.rs);
            end
        end
    end

    // Sequencer: next state, accounting and memory control.
    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        used_next     = used_reg;
        cap_next      = cap_reg;
        cap_en_next   = cap_en_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        acc_a_next    = acc_a_reg;
        acc_b_next    = acc_b_reg;
        status_next   = status_reg;
        rcap_next     = rcap_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_rcap_next   = m_rcap_reg;
        m_used_next   = m_used_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[IDX_W-1:0];
        mem_wdata     = upd;
        mem_re        = 1'b0;
        mem_raddr     = idx_reg[IDX_W-1:0];
        s_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                status_next = STAT_OK;
                rcap_next   = '0;
                idx_next    = '0;
                wr_next     = '0;
                acc_a_next  = '0;
                acc_b_next  = '0;
                state_next  = ST_FINISH;
                case (op_reg)
                    OP_MAP: begin
                        if ((map_c != '0) && cap_en_reg && (map_sum > cap_ext)) begin
                            status_next = STAT_REFUSED;
                        end else if (!os_ok_reg) begin
                            status_next = STAT_OS_FAIL;
                        end else begin
                            if (cap_en_reg) begin
                                used_next = USED_W'(map_sum);
                            end
                            mode_next  = WM_UNTRACK;
                            state_next = fixed_reg ? ST_WALK_RD : ST_APPEND;
                        end
                    end
                    OP_PROTECT: begin
                        if (usable_reg) begin
                            mode_next  = WM_COMMIT_SUM;
                            state_next = ST_WALK_RD;
                        end else if (!os_ok_reg) begin
                            status_next = STAT_OS_FAIL;
                        end else begin
                            mode_next  = WM_DECOMMIT;
                            state_next = ST_WALK_RD;
                        end
                    end
                    OP_UNMAP: begin
                        mode_next  = WM_UNTRACK;
                        state_next = ST_WALK_RD;
                    end
                    OP_HEADROOM: begin
                        if (hb_bad) begin
                            status_next = STAT_HEADROOM;
                        end else begin
                            cap_next    = USED_W'(nc);
                            cap_en_next = 1'b1;
                            rcap_next   = RCAP_W'(nc);
                        end
                    end
                    default: begin
                        status_next = STAT_OK;
                    end
                endcase
            end

            ST_WALK_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = ST_POST;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_WALK_EV;
                end
            end

            ST_WALK_EV: begin
                state_next = ST_WALK_WR;
            end

            ST_WALK_WR: begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_WALK_RD;
                case (mode_reg)
                    WM_UNTRACK: begin
                        // Survivors are packed down to the write index.
                        if (ov) begin
                            acc_a_next = acc_a_reg + ACC_W'(rel);
                        end
                        if (!(ov && full)) begin
                            mem_we    = 1'b1;
                            mem_waddr = wr_reg[IDX_W-1:0];
                            wr_next   = wr_reg + 1'b1;
                        end
                    end
                    WM_COMMIT_SUM: begin
                        if (ov) begin
                            acc_b_next = acc_b_reg + ACC_W'(inter);
                            if (ev.charged < inter) begin
                                acc_a_next = acc_a_reg + ACC_W'(inter - ev.charged);
                            end
                        end
                    end
                    WM_APPLY_COMMIT: begin
                        if (ov && (ev.charged < inter)) begin
                            mem_we            = 1'b1;
                            mem_wdata.start   = ev.rs;
                            mem_wdata.size    = ev.size;
                            mem_wdata.charged = (inter > ev.size) ? ev.size : inter;
                        end
                    end
                    WM_DECOMMIT: begin
                        if (ov) begin
                            mem_we            = 1'b1;
                            mem_wdata.start   = ev.rs;
                            mem_wdata.size    = ev.size;
                            mem_wdata.charged = ev.charged - rel;
                            acc_a_next        = acc_a_reg + ACC_W'(rel);
                        end
                    end
                    default: begin
                        state_next = ST_WALK_RD;
                    end
                endcase
            end

            ST_POST: begin
                state_next = ST_FINISH;
                case (mode_reg)
                    WM_UNTRACK: begin
                        count_next = wr_reg;
                        if (op_reg == OP_MAP) begin
                            if (cap_en_reg) begin
                                used_next = used_reg - $signed(acc_a_reg[USED_W-1:0]);
                            end
                            state_next = ST_APPEND;
                        end else if (os_ok_reg) begin
                            if (cap_en_reg) begin
                                used_next = used_reg - $signed(acc_a_reg[USED_W-1:0]);
                            end
                        end else begin
                            status_next = STAT_OS_FAIL;
                        end
                    end
                    WM_COMMIT_SUM: begin
                        if (d_pos && cap_en_reg && (charge_sum > cap_ext)) begin
                            status_next = STAT_REFUSED;
                        end else if (!os_ok_reg) begin
                            status_next = STAT_OS_FAIL;
                        end else begin
                            if (d_pos && cap_en_reg) begin
                                used_next = USED_W'(charge_sum);
                            end
                            mode_next  = WM_APPLY_COMMIT;
                            idx_next   = '0;
                            state_next = ST_WALK_RD;
                        end
                    end
                    WM_DECOMMIT: begin
                        if (cap_en_reg) begin
                            used_next = used_reg - $signed(acc_a_reg[USED_W-1:0]);
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_APPEND: begin
                // A full table drops the new region.
                if (count_reg < SLOTS_CNT) begin
                    mem_we            = 1'b1;
                    mem_waddr         = count_reg[IDX_W-1:0];
                    mem_wdata.start   = START_W'(base_reg);
                    mem_wdata.size    = len_reg;
                    mem_wdata.charged = map_c;
                    count_next        = count_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_rcap_next   = rcap_reg;
                    m_used_next   = used_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The user keeps configuration writes to idle; the block does not check.
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CAP_CONFIGURED: begin
                    cap_en_next = cfg_data[0];
                end
                CFG_CAP_LIMIT: begin
                    if ((cfg_data[LIMIT_W-1:0] != '0) && (cfg_data[LIMIT_W-1:0] <= MAX_CAP)) begin
                        cap_next = USED_W'(cfg_data[LIMIT_W-1:0]);
                    end else begin
                        cap_next = '0;
                    end
                end
                CFG_INITIAL_USED: begin
                    used_next = USED_W'(cfg_data);
                end
                default: begin
                    cap_en_next = cap_en_reg;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_returned_cap = m_rcap_reg;
    assign m_used_bytes   = m_used_reg;

endmodule

### rtl/core/cqg_region_mem.sv
// Region table memory: one write port and one read port with registered data.
module cqg_region_mem #(
    parameter int DEPTH = cqg_pkg::DEFAULT_REGION_SLOTS,
    parameter int IDX_W = 6
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  cqg_pkg::region_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output cqg_pkg::region_entry_t rd_data
);
    import cqg_pkg::*;

    region_entry_t mem [DEPTH];
    region_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/cqg_region_eval.sv
// Overlap stage: clips one region against the request range and registers the bounds.
module cqg_region_eval (
    input  logic                        aclk,
    input  logic                        load,
    input  cqg_pkg::region_entry_t      entry,
    input  logic [cqg_pkg::ADDR_W-1:0]  range_base,
    input  logic [cqg_pkg::START_W-1:0] range_end,
    output cqg_pkg::region_eval_t       result
);
    import cqg_pkg::*;

    region_eval_t  result_reg;
    region_eval_t  result_next;
    logic [END_W-1:0]   re;
    logic [START_W-1:0] base_ext;

    // Region end, then the intersection bounds.
    always_comb begin
        re       = END_W'(entry.start) + END_W'(entry.size);
        base_ext = START_W'(range_base);
        result_next.rs      = entry.start;
        result_next.re      = re;
        result_next.size    = entry.size;
        result_next.charged = entry.charged;
        result_next.is_lo   = (base_ext > entry.start) ? base_ext : entry.start;
        result_next.ie_hi   = (END_W'(range_end) < re) ? range_end : START_W'(re);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### rtl/core/cqg_checker.sv
// Port checker of the committed memory quota guard and its bind.
module cqg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [1:0]                     m_status,
    input logic [cqg_pkg::RCAP_W-1:0]     m_returned_cap,
    input logic [cqg_pkg::USED_W-1:0]     m_used_bytes
);
    import cqg_pkg::*;

    // A returned cap only comes with a successful beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_returned_cap != '0)) |-> (m_status == STAT_OK))
        else $error("returned cap on a failed beat");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
            && $stable(m_returned_cap) && $stable(m_used_bytes)))
        else $error("stalled result beat changed");

endmodule

bind committed_memory_quota_guard cqg_checker u_cqg_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_returned_cap (m_returned_cap),
    .m_used_bytes   (m_used_bytes)
);
